[sv/cms_pkg.sv]
// ----------------------------------------------------------------------------
// cms_pkg: shared types and constants of the cyclic message scheduler
// Item layouts, request codes, period codes and default sizes.
// ----------------------------------------------------------------------------
package cms_pkg;

	// Default sizes
	localparam int DEF_TABLE_DEPTH    = 28;
	localparam int DEF_TICKS_PER_SLOT = 10;

	// Slot counter wraps after 500 ms
	localparam logic [5:0] SLOT_WRAP = 6'd50;
	localparam logic [7:0] TICK_MAX  = 8'd255;

	// Request codes
	localparam logic [1:0] REQ_ADD  = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_POLL = 2'd2;

	// Period codes
	localparam logic [2:0] CODE_10MS  = 3'd0;
	localparam logic [2:0] CODE_20MS  = 3'd1;
	localparam logic [2:0] CODE_50MS  = 3'd2;
	localparam logic [2:0] CODE_100MS = 3'd3;
	localparam logic [2:0] CODE_500MS = 3'd4;
	localparam logic [2:0] CODE_NUM   = 3'd5;

	// Result kinds and add status
	localparam logic KIND_ADD_STATUS = 1'b0;
	localparam logic KIND_SEND       = 1'b1;
	localparam logic STATUS_STORED   = 1'b0;
	localparam logic STATUS_FULL     = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] period_code;
		logic [4:0] buffer_index;
	} sched_req_t;

	typedef struct packed {
		logic       result_kind;
		logic       add_status;
		logic [4:0] send_buffer;
		logic       channel;
		logic       last;
	} sched_rsp_t;

	// One table entry as stored in the RAM
	typedef struct packed {
		logic [2:0] period;
		logic [4:0] buffer;
	} entry_t;

endpackage

[sv/cms_ram.sv]
// ----------------------------------------------------------------------------
// cms_ram: generic simple dual-port RAM
// One write and one read per cycle; read data is registered and holds
// until the next read.
// ----------------------------------------------------------------------------
module cms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 28
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                 wr_data,
	input  logic                             rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                 rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/cyclic_message_scheduler.sv]
// Timing: an add status is set into the held result and leaves through the output register;
//   add, tick, ignored and not-due poll items pass through the flush state. A due poll
//   steps through every period group and, for each due group, reads each stored entry in
//   turn through the single table read port; output stalls lengthen the walk.
// Throughput: one item at a time; results leave through an output register.
// Reset: arst_n (async, active low) clears counters, channel and control; table left as is.
// ----------------------------------------------------------------------------
// cyclic_message_scheduler: periodic CAN message scheduler
// Stores message entries, counts millisecond ticks and, on a due poll, walks
// the table once per due period group and emits send requests.
// ----------------------------------------------------------------------------
module cyclic_message_scheduler #(
	parameter int         TABLE_DEPTH    = cms_pkg::DEF_TABLE_DEPTH,
	parameter logic [7:0] TICKS_PER_SLOT = 8'(cms_pkg::DEF_TICKS_PER_SLOT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                req_valid,
	output logic                req_stall,
	input  cms_pkg::sched_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output cms_pkg::sched_rsp_t rsp
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_NEXT  = 5'b00010,
		ST_READ  = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t              state_q;
	logic                chan_q;
	logic [CNT_W-1:0]    count_q;
	logic [7:0]          ticks_q;
	logic [5:0]          slot_q;
	logic [2:0]          cnt5_q;
	logic [3:0]          cnt10_q;
	logic [4:0]          due_q;
	logic [2:0]          code_q;
	logic [CNT_W-1:0]    idx_q;
	cms_pkg::sched_rsp_t pend_q;
	logic                pend_valid_q;
	cms_pkg::sched_rsp_t out_q;
	logic                out_valid_q;

	logic                accept;
	logic                full;
	logic                slot_due;
	logic [5:0]          slot_inc;
	logic [2:0]          cnt5_inc;
	logic [3:0]          cnt10_inc;
	logic                out_free;
	logic [CNT_W-1:0]    idx_inc;
	logic                ram_wr_en;
	logic                ram_rd_en;
	cms_pkg::entry_t     wr_entry;
	cms_pkg::entry_t     rd_entry;
	logic                match;
	cms_pkg::sched_rsp_t send_item;
	cms_pkg::sched_rsp_t status_item;
	cms_pkg::sched_rsp_t out_item;
	logic                load_out;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign full      = (count_q >= CNT_W'(TABLE_DEPTH));
	assign slot_due  = (ticks_q >= TICKS_PER_SLOT);
	assign slot_inc  = slot_q + 6'd1;
	assign cnt5_inc  = (cnt5_q == 3'd4) ? 3'd0 : cnt5_q + 3'd1;
	assign cnt10_inc = (cnt10_q == 4'd9) ? 4'd0 : cnt10_q + 4'd1;
	assign out_free  = !out_valid_q || !rsp_stall;
	assign idx_inc   = idx_q + CNT_W'(1);

	// Table storage
	assign ram_wr_en = (state_q == ST_IDLE) && accept
		&& (req.req_type == cms_pkg::REQ_ADD) && !full;
	assign ram_rd_en = (state_q == ST_READ);
	assign wr_entry.period = req.period_code;
	assign wr_entry.buffer = req.buffer_index;

	cms_ram #(
		.WIDTH($bits(cms_pkg::entry_t)),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(count_q[IDX_W-1:0]),
		.wr_data(wr_entry),
		.rd_en  (ram_rd_en),
		.rd_addr(idx_q[IDX_W-1:0]),
		.rd_data(rd_entry)
	);

	// Compare the read entry against the period group being walked
	assign match = (rd_entry.period == code_q);
	always_comb begin
		send_item             = '0;
		send_item.result_kind = cms_pkg::KIND_SEND;
		send_item.add_status  = cms_pkg::STATUS_STORED;
		send_item.send_buffer = rd_entry.buffer;
		send_item.channel     = chan_q;
		send_item.last        = 1'b0;
	end

	// Build the add status for the item being taken
	always_comb begin
		status_item             = '0;
		status_item.result_kind = cms_pkg::KIND_ADD_STATUS;
		status_item.add_status  = full ? cms_pkg::STATUS_FULL : cms_pkg::STATUS_STORED;
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= 1'b0;
		end else if (cfg_wr_en) begin
			chan_q <= cfg_wr_data;
		end
	end

	// Sequencer, counters and the held result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			ticks_q      <= '0;
			slot_q       <= '0;
			cnt5_q       <= '0;
			cnt10_q      <= '0;
			due_q        <= '0;
			code_q       <= '0;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ((req.req_type == cms_pkg::REQ_POLL) && slot_due)
							? ST_NEXT : ST_FLUSH;
						case (req.req_type)
							cms_pkg::REQ_ADD: begin
								pend_valid_q <= 1'b1;
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							cms_pkg::REQ_TICK: begin
								if (ticks_q != cms_pkg::TICK_MAX) begin
									ticks_q <= ticks_q + 8'd1;
								end
							end
							cms_pkg::REQ_POLL: begin
								if (slot_due) begin
									ticks_q  <= '0;
									cnt5_q   <= cnt5_inc;
									cnt10_q  <= cnt10_inc;
									slot_q   <= (slot_inc >= cms_pkg::SLOT_WRAP) ? '0 : slot_inc;
									due_q[cms_pkg::CODE_10MS]  <= 1'b1;
									due_q[cms_pkg::CODE_20MS]  <= !slot_inc[0];
									due_q[cms_pkg::CODE_50MS]  <= (cnt5_inc == 3'd0);
									due_q[cms_pkg::CODE_100MS] <= (cnt10_inc == 4'd0);
									due_q[cms_pkg::CODE_500MS] <= (slot_inc >= cms_pkg::SLOT_WRAP);
									code_q   <= cms_pkg::CODE_10MS;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_NEXT: begin
					// Pick the next due group, or finish
					if (code_q == cms_pkg::CODE_NUM) begin
						state_q <= ST_FLUSH;
					end else if (due_q[code_q] && (count_q != '0)) begin
						idx_q   <= '0;
						state_q <= ST_READ;
					end else begin
						code_q <= code_q + 3'd1;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					// Hold while a match must push the held result into a full output
					if (!(match && pend_valid_q && !out_free)) begin
						if (match) begin
							pend_valid_q <= 1'b1;
						end
						if (idx_inc == count_q) begin
							code_q  <= code_q + 3'd1;
							state_q <= ST_NEXT;
						end else begin
							idx_q   <= idx_inc;
							state_q <= ST_READ;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Held result payload
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && accept && (req.req_type == cms_pkg::REQ_ADD)) begin
			pend_q <= status_item;
		end else if ((state_q == ST_CHECK) && match && !(pend_valid_q && !out_free)) begin
			pend_q <= send_item;
		end
	end

	// Move the held result out on a new match or at the flush; the flush marks the final one
	assign load_out = pend_valid_q && out_free
		&& (((state_q == ST_CHECK) && match) || (state_q == ST_FLUSH));
	always_comb begin
		out_item      = pend_q;
		out_item.last = (state_q == ST_FLUSH);
	end

	// Output register valid: set on load, drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_item;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

[sv/cms_checker.sv]
// ----------------------------------------------------------------------------
// cms_checker: port-level checks for the cyclic message scheduler
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module cms_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input cms_pkg::sched_rsp_t rsp
);

	// Hold a stalled result
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed or dropped");

	// Every accepted item keeps the block busy in the cycle after it is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("block took a second item without working the first");

	// Add status is always the only and final result, with empty payload
	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.result_kind == cms_pkg::KIND_ADD_STATUS)
		|-> rsp.last && (rsp.send_buffer == 5'd0) && !rsp.channel)
		else $error("malformed add status result");

	// Send requests never report a full table
	a_send_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.result_kind == cms_pkg::KIND_SEND) |-> !rsp.add_status)
		else $error("send request carries add status");

endmodule

bind cyclic_message_scheduler cms_checker u_cms_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp)
);
